// ===== src/aesd_pkg.sv =====
`default_nettype none
package aesd_pkg;

	localparam int NumRoundsDefault = 10;

	typedef enum logic {
		OP_KEY_WRITE = 1'b0,
		OP_DECRYPT   = 1'b1
	} op_t;

	typedef struct packed {
		logic        operation;
		logic [3:0]  key_slot;
		logic [63:0] word_high;
		logic [63:0] word_low;
	} in_beat_t;

	typedef struct packed {
		logic [63:0] plain_high;
		logic [63:0] plain_low;
	} out_beat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_ROUND,
		ST_DONE
	} state_t;

	// Control from the sequencer to the round unit.
	typedef struct packed {
		logic load;
		logic first;
		logic mix;
		logic last;
	} rnd_ctl_t;

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] p;
		acc = 8'h00;
		p = a;
		for (int i = 0; i < 4; i++) begin
			if (b[i]) acc = acc ^ p;
			p = xt(p);
		end
		return acc;
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
		return t[x];
	endfunction

endpackage
`default_nettype wire

// ===== src/aesd_ram.sv =====
`default_nettype none
module aesd_ram #(
	parameter int Width = 128,
	parameter int Depth = 11
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== src/aesd_round.sv =====
`default_nettype none
module aesd_round
	import aesd_pkg::*;
(
	input  wire logic         clk,
	input  wire rnd_ctl_t     ctl,
	input  wire logic [127:0] din,
	input  wire logic [127:0] rkey,
	output logic      [127:0] state
);
	logic [127:0] state_q;
	logic [127:0] ark;
	logic [127:0] mixed;
	logic [127:0] shsub;
	logic [7:0]   b [16];
	logic [7:0]   m [16];

	// The key add sees the fresh block on the first round, else the state.
	assign ark = (ctl.first ? din : state_q) ^ rkey;

	always_comb begin
		for (int i = 0; i < 16; i++) b[i] = ark[127-8*i -: 8];
		for (int c = 0; c < 4; c++) begin
			m[4*c]   = gmul(b[4*c],8'h0e)^gmul(b[4*c+1],8'h0b)^gmul(b[4*c+2],8'h0d)
				^gmul(b[4*c+3],8'h09);
			m[4*c+1] = gmul(b[4*c],8'h09)^gmul(b[4*c+1],8'h0e)^gmul(b[4*c+2],8'h0b)
				^gmul(b[4*c+3],8'h0d);
			m[4*c+2] = gmul(b[4*c],8'h0d)^gmul(b[4*c+1],8'h09)^gmul(b[4*c+2],8'h0e)
				^gmul(b[4*c+3],8'h0b);
			m[4*c+3] = gmul(b[4*c],8'h0b)^gmul(b[4*c+1],8'h0d)^gmul(b[4*c+2],8'h09)
				^gmul(b[4*c+3],8'h0e);
		end
		for (int i = 0; i < 16; i++) mixed[127-8*i -: 8] = ctl.mix ? m[i] : b[i];
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				shsub[127-8*(r+4*((c+r)%4)) -: 8] = inv_sbox(mixed[127-8*(r+4*c) -: 8]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) state_q <= ctl.last ? ark : shsub;
	end

	assign state = state_q;
endmodule
`default_nettype wire

// ===== src/aes128_block_decrypt.sv =====
// Channel | Direction | Handshake     | Payload
// in      | input     | valid, stall  | in_beat_t
// out     | output    | valid, stall  | out_beat_t
// A decrypt applies NUM_ROUNDS + 1 round keys, one per cycle through the single round
// unit, which reads one key per cycle from the key store's single read port; the
// result is presented after the last round, and a new beat is taken only once the
// previous result has left. Reset clears the sequencer; the key store is undefined
// until written. A finished block waits in the output register while out.stall is
// high; input stall stays high from acceptance of a decrypt until its beat leaves.
`default_nettype none
module aes128_block_decrypt
	import aesd_pkg::*;
#(
	parameter int NUM_ROUNDS = NumRoundsDefault
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_beat_t  in_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_beat_t      out_data
);
	localparam int Slots = NUM_ROUNDS + 1;
	localparam int Aw = $clog2(Slots);

	state_t         state_q, state_d;
	logic [Aw-1:0]  rnd_q;
	logic [127:0]   blk_q;
	logic [127:0]   rkey;
	logic [127:0]   st;
	logic [Aw-1:0]  raddr;
	logic           accept, kwrite;
	rnd_ctl_t       ctl;

	assign accept = in_valid && !in_stall;
	assign kwrite = accept && in_data.operation == OP_KEY_WRITE
		&& in_data.key_slot < 4'(Slots);

	always_comb begin
		raddr = rnd_q;
		if (state_q == ST_IDLE) raddr = Aw'(NUM_ROUNDS);
		else if (state_q == ST_FETCH || state_q == ST_ROUND) raddr = rnd_q - 1'b1;
	end

	aesd_ram #(.Width(128), .Depth(Slots)) u_keys (
		.clk   (clk),
		.we    (kwrite),
		.waddr (in_data.key_slot[Aw-1:0]),
		.wdata ({in_data.word_high, in_data.word_low}),
		.raddr (raddr),
		.rdata (rkey)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept && in_data.operation == OP_DECRYPT) state_d = ST_FETCH;
			ST_FETCH: state_d = ST_ROUND;
			ST_ROUND: if (rnd_q == '0) state_d = ST_DONE;
			ST_DONE:  if (!out_stall) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		in_stall = state_q != ST_IDLE;
		out_valid = state_q == ST_DONE;
		if (state_q == ST_FETCH || state_q == ST_ROUND) begin
			ctl.load = 1'b1;
			ctl.first = state_q == ST_FETCH;
			ctl.mix = state_q == ST_ROUND && rnd_q != '0;
			ctl.last = state_q == ST_ROUND && rnd_q == '0;
		end
	end

	// rnd_q holds the index of the key being applied in the current cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) rnd_q <= Aw'(NUM_ROUNDS);
			else if (state_q == ST_FETCH || state_q == ST_ROUND) rnd_q <= rnd_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) blk_q <= {in_data.word_high, in_data.word_low};
	end

	aesd_round u_round (
		.clk   (clk),
		.ctl   (ctl),
		.din   (blk_q),
		.rkey  (rkey),
		.state (st)
	);

	assign out_data = {st[127:64], st[63:0]};

	a_done_after_round: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND && rnd_q == '0 |=> out_valid)
		else $error("result not presented after last round");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !accept)
		else $error("item accepted while busy");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
endmodule
`default_nettype wire
